// File: hw/rtl/cfn_pkg.sv
// ----------------------------------------------------------------------------
// cfn_pkg: shared types and constants of the coverage navigation unit
// Command, mode and event codes, register indexes, hold times and the
// result burst that one sensor sample produces.
// ----------------------------------------------------------------------------
`default_nettype none

package cfn_pkg;

  localparam int DIST_WIDTH_DEF   = 10;
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int ROW_MARGIN_WIDTH = 8;
  localparam int HOLD_WIDTH       = 11;
  localparam int KIND_WIDTH       = 2;
  localparam int CFG_INDEX_WIDTH  = 3;
  localparam int CFG_DIST_REGS    = 6;
  localparam int MAX_RESULTS      = 4;
  localparam int BURST_IDX_WIDTH  = $clog2(MAX_RESULTS);

  // Register indexes on the configuration channel.
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_DISTANCE   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MIN_DISTANCE   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_BLOCK_DISTANCE = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OPEN_THRESHOLD = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_END_RIGHT      = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_END_LEFT       = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_ROW_MARGIN     = 3'd6;

  // Register reset values.
  localparam int RST_MAX_DISTANCE   = 40;
  localparam int RST_MIN_DISTANCE   = 2;
  localparam int RST_BLOCK_DISTANCE = 20;
  localparam int RST_OPEN_THRESHOLD = 17;
  localparam int RST_END_RIGHT      = 14;
  localparam int RST_END_LEFT       = 15;
  localparam int RST_ROW_MARGIN     = 3;

  localparam logic [HOLD_WIDTH-1:0] HOLD_NONE  = 11'd0;
  localparam logic [HOLD_WIDTH-1:0] HOLD_PAUSE = 11'd300;
  localparam logic [HOLD_WIDTH-1:0] HOLD_LEFT  = 11'd1500;
  localparam logic [HOLD_WIDTH-1:0] HOLD_RIGHT = 11'd1700;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_LEFT   = 2'd1,
    KIND_RIGHT  = 2'd2,
    KIND_START  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CMD_STRAIGHT = 2'd0,
    CMD_STOP     = 2'd1,
    CMD_LEFT     = 2'd2,
    CMD_RIGHT    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_STOP = 3'b001,
    MODE_FIND = 3'b010,
    MODE_SCAN = 3'b100
  } mode_t;

  localparam logic [1:0] MODE_CODE_STOP = 2'd0;
  localparam logic [1:0] MODE_CODE_FIND = 2'd1;
  localparam logic [1:0] MODE_CODE_SCAN = 2'd2;

  // One result item; the layout is the output tdata, lowest field last.
  typedef struct packed {
    logic                  led_on;
    logic [1:0]            mode_now;
    logic [HOLD_WIDTH-1:0] hold_ms;
    cmd_t                  motor_command;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0]  entry;
    logic [BURST_IDX_WIDTH-1:0] last_idx;
  } burst_t;

  function automatic logic [1:0] mode_code(input mode_t m);
    logic [1:0] code;
    unique case (m)
      MODE_FIND: code = MODE_CODE_FIND;
      MODE_SCAN: code = MODE_CODE_SCAN;
      default:   code = MODE_CODE_STOP;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cfn_cfg.sv
// ----------------------------------------------------------------------------
// cfn_cfg: configuration registers
// Holds the six distance thresholds and the row margin, written by index.
// ----------------------------------------------------------------------------
`default_nettype none

module cfn_cfg #(
  parameter int DIST_WIDTH     = cfn_pkg::DIST_WIDTH_DEF,
  parameter int CFG_DATA_WIDTH = cfn_pkg::DIST_WIDTH_DEF
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               cfg_valid,
  output logic                                               cfg_ready,
  input  logic [cfn_pkg::CFG_INDEX_WIDTH-1:0]                cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]                          cfg_data,
  output logic [cfn_pkg::CFG_DIST_REGS-1:0][DIST_WIDTH-1:0]  dist_cfg,
  output logic [cfn_pkg::ROW_MARGIN_WIDTH-1:0]               row_margin
);
  import cfn_pkg::*;

  logic write;

  assign cfg_ready = 1'b1;
  assign write     = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dist_cfg[CFG_MAX_DISTANCE]   <= DIST_WIDTH'(RST_MAX_DISTANCE);
      dist_cfg[CFG_MIN_DISTANCE]   <= DIST_WIDTH'(RST_MIN_DISTANCE);
      dist_cfg[CFG_BLOCK_DISTANCE] <= DIST_WIDTH'(RST_BLOCK_DISTANCE);
      dist_cfg[CFG_OPEN_THRESHOLD] <= DIST_WIDTH'(RST_OPEN_THRESHOLD);
      dist_cfg[CFG_END_RIGHT]      <= DIST_WIDTH'(RST_END_RIGHT);
      dist_cfg[CFG_END_LEFT]       <= DIST_WIDTH'(RST_END_LEFT);
      row_margin                   <= ROW_MARGIN_WIDTH'(RST_ROW_MARGIN);
    end else if (write) begin
      unique case (cfg_index)
        CFG_MAX_DISTANCE:   dist_cfg[CFG_MAX_DISTANCE]   <= cfg_data[DIST_WIDTH-1:0];
        CFG_MIN_DISTANCE:   dist_cfg[CFG_MIN_DISTANCE]   <= cfg_data[DIST_WIDTH-1:0];
        CFG_BLOCK_DISTANCE: dist_cfg[CFG_BLOCK_DISTANCE] <= cfg_data[DIST_WIDTH-1:0];
        CFG_OPEN_THRESHOLD: dist_cfg[CFG_OPEN_THRESHOLD] <= cfg_data[DIST_WIDTH-1:0];
        CFG_END_RIGHT:      dist_cfg[CFG_END_RIGHT]      <= cfg_data[DIST_WIDTH-1:0];
        CFG_END_LEFT:       dist_cfg[CFG_END_LEFT]       <= cfg_data[DIST_WIDTH-1:0];
        CFG_ROW_MARGIN:     row_margin <= cfg_data[ROW_MARGIN_WIDTH-1:0];
        default: begin
          // Writes beyond the register list are dropped.
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/cfn_step.sv
// ----------------------------------------------------------------------------
// cfn_step: per-item decision logic
// Clamps the distances, decides the mode transition and builds the burst
// of motor commands for one event, along with the next navigation state.
// ----------------------------------------------------------------------------
`default_nettype none

module cfn_step #(
  parameter int DIST_WIDTH  = cfn_pkg::DIST_WIDTH_DEF,
  parameter int COUNT_WIDTH = cfn_pkg::COUNT_WIDTH_DEF
) (
  input  cfn_pkg::kind_t                                     kind,
  input  logic [DIST_WIDTH-1:0]                              dist_right,
  input  logic [DIST_WIDTH-1:0]                              dist_left,
  input  logic [DIST_WIDTH-1:0]                              dist_front,
  input  logic [cfn_pkg::CFG_DIST_REGS-1:0][DIST_WIDTH-1:0]  dist_cfg,
  input  logic [cfn_pkg::ROW_MARGIN_WIDTH-1:0]               row_margin,
  input  cfn_pkg::mode_t                                     mode,
  input  logic [COUNT_WIDTH-1:0]                             left_pulses,
  input  logic [COUNT_WIDTH-1:0]                             row_length,
  input  logic                                               turn_left_next,
  output cfn_pkg::mode_t                                     mode_next,
  output logic [COUNT_WIDTH-1:0]                             left_pulses_next,
  output logic [COUNT_WIDTH-1:0]                             row_length_next,
  output logic                                               turn_left_next_next,
  output cfn_pkg::burst_t                                    burst
);
  import cfn_pkg::*;

  function automatic logic [DIST_WIDTH-1:0] clamp_dist(input logic [DIST_WIDTH-1:0] v,
                                                       input logic [DIST_WIDTH-1:0] mx,
                                                       input logic [DIST_WIDTH-1:0] mn);
    return (v > mx || v < mn) ? mx : v;
  endfunction

  logic [DIST_WIDTH-1:0]  r_dist;
  logic [DIST_WIDTH-1:0]  l_dist;
  logic [DIST_WIDTH-1:0]  f_dist;
  logic [DIST_WIDTH-1:0]  block_dist;
  logic [DIST_WIDTH-1:0]  open_thr;
  logic [COUNT_WIDTH:0]   row_target;
  logic                   row_end;
  cmd_t                   cmd   [MAX_RESULTS];
  logic [HOLD_WIDTH-1:0]  hold  [MAX_RESULTS];
  logic [BURST_IDX_WIDTH-1:0] last_idx;

  assign r_dist = clamp_dist(dist_right, dist_cfg[CFG_MAX_DISTANCE], dist_cfg[CFG_MIN_DISTANCE]);
  assign l_dist = clamp_dist(dist_left, dist_cfg[CFG_MAX_DISTANCE], dist_cfg[CFG_MIN_DISTANCE]);
  assign f_dist = clamp_dist(dist_front, dist_cfg[CFG_MAX_DISTANCE], dist_cfg[CFG_MIN_DISTANCE]);

  assign block_dist = dist_cfg[CFG_BLOCK_DISTANCE];
  assign open_thr   = dist_cfg[CFG_OPEN_THRESHOLD];

  // The sum keeps its carry so a target beyond the pulse counter is never reached.
  assign row_target = {1'b0, row_length} + (COUNT_WIDTH + 1)'(row_margin);
  assign row_end    = {1'b0, left_pulses} >= row_target;

  always_comb begin
    mode_next           = mode;
    left_pulses_next    = left_pulses;
    row_length_next     = row_length;
    turn_left_next_next = turn_left_next;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      cmd[k]  = CMD_STRAIGHT;
      hold[k] = HOLD_NONE;
    end
    last_idx = '0;

    unique case (kind)
      KIND_LEFT: begin
        if (left_pulses != '1) left_pulses_next = left_pulses + 1'b1;
      end
      KIND_RIGHT: begin
      end
      KIND_START: begin
        mode_next = MODE_FIND;
      end
      KIND_SAMPLE: begin
        unique case (mode)
          MODE_FIND: begin
            if (f_dist <= block_dist) begin
              row_length_next  = left_pulses;
              left_pulses_next = '0;
              mode_next        = MODE_SCAN;
              if (r_dist <= block_dist) begin
                cmd[1]              = CMD_STOP;
                hold[1]             = HOLD_PAUSE;
                cmd[2]              = CMD_LEFT;
                hold[2]             = HOLD_LEFT;
                last_idx            = BURST_IDX_WIDTH'(2);
                turn_left_next_next = 1'b0;
              end else if (l_dist <= block_dist) begin
                cmd[1]              = CMD_STOP;
                hold[1]             = HOLD_PAUSE;
                cmd[2]              = CMD_RIGHT;
                hold[2]             = HOLD_RIGHT;
                last_idx            = BURST_IDX_WIDTH'(2);
                turn_left_next_next = 1'b1;
              end
            end
          end
          MODE_SCAN: begin
            if (row_end) begin
              left_pulses_next = '0;
              if (l_dist >= open_thr && turn_left_next) begin
                cmd[1]              = CMD_STOP;
                hold[1]             = HOLD_PAUSE;
                cmd[2]              = CMD_LEFT;
                hold[2]             = HOLD_LEFT;
                cmd[3]              = CMD_STOP;
                last_idx            = BURST_IDX_WIDTH'(3);
                turn_left_next_next = 1'b0;
              end else if (r_dist >= open_thr && !turn_left_next) begin
                cmd[1]              = CMD_STOP;
                hold[1]             = HOLD_PAUSE;
                cmd[2]              = CMD_RIGHT;
                hold[2]             = HOLD_RIGHT;
                cmd[3]              = CMD_STOP;
                last_idx            = BURST_IDX_WIDTH'(3);
                turn_left_next_next = 1'b1;
              end else if ((r_dist < dist_cfg[CFG_END_RIGHT] && !turn_left_next) ||
                           (l_dist < dist_cfg[CFG_END_LEFT] && turn_left_next)) begin
                mode_next = MODE_STOP;
              end
            end
          end
          default: begin
            mode_next = MODE_STOP;
            cmd[0]    = CMD_STOP;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Every result of a burst reports the mode left behind by the whole step.
  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      burst.entry[k].motor_command = cmd[k];
      burst.entry[k].hold_ms       = hold[k];
      burst.entry[k].mode_now      = mode_code(mode_next);
      burst.entry[k].led_on        = (mode_next == MODE_STOP);
    end
    burst.last_idx = last_idx;
  end

endmodule

`default_nettype wire

// File: hw/rtl/cfn_burst.sv
// ----------------------------------------------------------------------------
// cfn_burst: result register and output sequencer
// Holds the command burst of one sample and sends its results one per cycle
// while m_tready is high; the next burst can load as the last one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module cfn_burst (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  cfn_pkg::burst_t                burst_in,
  output logic                           free,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [$bits(cfn_pkg::result_t)-1:0] m_tdata,
  output logic                           m_tlast
);
  import cfn_pkg::*;

  logic                       valid;
  logic [BURST_IDX_WIDTH-1:0] idx;
  burst_t                     burst;
  logic                       take;
  logic                       done;

  assign take = valid && m_tready;
  assign done = take && (idx == burst.last_idx);
  assign free = !valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (done) begin
      valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) burst <= burst_in;
  end

  assign m_tvalid = valid;
  assign m_tdata  = burst.entry[idx];
  assign m_tlast  = (idx == burst.last_idx);

endmodule

`default_nettype wire

// File: hw/rtl/coverage_navigation_fsm_unit.sv
// ----------------------------------------------------------------------------
// coverage_navigation_fsm_unit: back-and-forth floor coverage controller
// Takes wheel pulse, start and sensor events and issues motor commands
// with hold times for the stop, find and scan modes.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid/s_tready    tuser kind, tdata three distances
//   m_*      out        m_tvalid/m_tready    tdata command word, tlast end of burst
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An accepted event sits in the input register and is decided there; a
// sensor sample loads one to four results into the result register, which
// offers one per cycle while m_tready is high, the first in the cycle after
// the decision. Pulse and start events never wait for the result register
// and give no result. Reset is synchronous and clears the valid flags and
// the navigation and configuration state; m_tready low holds the output
// and lets one further event wait in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module coverage_navigation_fsm_unit #(
  parameter  int DIST_WIDTH     = cfn_pkg::DIST_WIDTH_DEF,
  parameter  int COUNT_WIDTH    = cfn_pkg::COUNT_WIDTH_DEF,
  localparam int CFG_DATA_WIDTH = (DIST_WIDTH > cfn_pkg::ROW_MARGIN_WIDTH) ?
                                  DIST_WIDTH : cfn_pkg::ROW_MARGIN_WIDTH,
  localparam int IN_DATA_WIDTH  = ((3 * DIST_WIDTH + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // dist_right, dist_left, dist_front, zero fill
  input  logic [IN_DATA_WIDTH-1:0]             s_tdata,
  // kind
  input  logic [cfn_pkg::KIND_WIDTH-1:0]       s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // motor_command, hold_ms, mode_now, led_on
  output logic [$bits(cfn_pkg::result_t)-1:0]  m_tdata,
  output logic                                 m_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cfn_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]            cfg_data
);
  import cfn_pkg::*;

  logic                                    in_valid;
  kind_t                                   in_kind;
  logic [DIST_WIDTH-1:0]                   in_right;
  logic [DIST_WIDTH-1:0]                   in_left;
  logic [DIST_WIDTH-1:0]                   in_front;
  logic                                    advance;
  logic                                    burst_free;

  logic [CFG_DIST_REGS-1:0][DIST_WIDTH-1:0] dist_cfg;
  logic [ROW_MARGIN_WIDTH-1:0]             row_margin;

  mode_t                                   mode;
  mode_t                                   mode_next;
  logic [COUNT_WIDTH-1:0]                  left_pulses;
  logic [COUNT_WIDTH-1:0]                  left_pulses_next;
  logic [COUNT_WIDTH-1:0]                  row_length;
  logic [COUNT_WIDTH-1:0]                  row_length_next;
  logic                                    turn_left_next;
  logic                                    turn_left_next_next;
  burst_t                                  burst;

  cfn_cfg #(
    .DIST_WIDTH     (DIST_WIDTH),
    .CFG_DATA_WIDTH (CFG_DATA_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .dist_cfg   (dist_cfg),
    .row_margin (row_margin)
  );

  // Events without results never wait for the result register.
  assign advance  = in_valid && ((in_kind != KIND_SAMPLE) || burst_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= kind_t'(s_tuser);
      in_right <= s_tdata[DIST_WIDTH-1:0];
      in_left  <= s_tdata[2*DIST_WIDTH-1:DIST_WIDTH];
      in_front <= s_tdata[3*DIST_WIDTH-1:2*DIST_WIDTH];
    end
  end

  cfn_step #(
    .DIST_WIDTH  (DIST_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .kind                (in_kind),
    .dist_right          (in_right),
    .dist_left           (in_left),
    .dist_front          (in_front),
    .dist_cfg            (dist_cfg),
    .row_margin          (row_margin),
    .mode                (mode),
    .left_pulses         (left_pulses),
    .row_length          (row_length),
    .turn_left_next      (turn_left_next),
    .mode_next           (mode_next),
    .left_pulses_next    (left_pulses_next),
    .row_length_next     (row_length_next),
    .turn_left_next_next (turn_left_next_next),
    .burst               (burst)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_STOP;
      left_pulses    <= '0;
      row_length     <= '0;
      turn_left_next <= 1'b0;
    end else if (advance) begin
      mode           <= mode_next;
      left_pulses    <= left_pulses_next;
      row_length     <= row_length_next;
      turn_left_next <= turn_left_next_next;
    end
  end

  cfn_burst u_burst (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && (in_kind == KIND_SAMPLE)),
    .burst_in (burst),
    .free     (burst_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

// File: hw/rtl/cfn_checker.sv
// ----------------------------------------------------------------------------
// cfn_checker: port-level checks of the result channel
// Watches the result stream for stalls, burst continuity, mode and reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cfn_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [$bits(cfn_pkg::result_t)-1:0]  m_tdata,
  input  logic                                 m_tlast
);
  import cfn_pkg::*;

  localparam int MODE_LSB = $bits(cmd_t) + HOLD_WIDTH;

  // A stalled result holds still.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // The results of one burst follow without gaps.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("burst interrupted");

  // Every result of a burst carries the same mode.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tdata[MODE_LSB+1:MODE_LSB] == $past(m_tdata[MODE_LSB+1:MODE_LSB]))
    else $error("mode changed inside a burst");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind coverage_navigation_fsm_unit cfn_checker u_cfn_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// File: bench/coverage_navigation_fsm_unit_test.sv
// ----------------------------------------------------------------------------
// coverage_navigation_fsm_unit_test: self-checking bench for the coverage unit
// Streams wheel pulse, start and sensor events into the unit and predicts
// every motor command burst in a scoreboard. The scoreboard keeps its own
// copy of the mode, pulse and row state. Both stream sides idle at random.
// The bench runs under several register settings.
// ----------------------------------------------------------------------------
module coverage_navigation_fsm_unit_test;
  import cfn_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PHASE_EVENTS  = 15;

  typedef struct packed {
    logic    last;
    result_t word;
  } expected_cmd_t;

  class nav_scoreboard;
    logic [9:0]      max_dist, min_dist, block_dist, open_thr, end_right, end_left;
    logic [7:0]      row_margin;
    logic [1:0]      mode;
    logic [15:0]     left_pulses, row_length;
    bit              turn_left_next;
    expected_cmd_t   burst[$];
    expected_cmd_t   expected[$];
    int              mismatches;

    function new();
      max_dist       = 10'(RST_MAX_DISTANCE);
      min_dist       = 10'(RST_MIN_DISTANCE);
      block_dist     = 10'(RST_BLOCK_DISTANCE);
      open_thr       = 10'(RST_OPEN_THRESHOLD);
      end_right      = 10'(RST_END_RIGHT);
      end_left       = 10'(RST_END_LEFT);
      row_margin     = 8'(RST_ROW_MARGIN);
      mode           = MODE_CODE_STOP;
      left_pulses    = '0;
      row_length     = '0;
      turn_left_next = 1'b0;
      mismatches     = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [9:0] val);
      case (idx)
        CFG_MAX_DISTANCE:   max_dist = val;
        CFG_MIN_DISTANCE:   min_dist = val;
        CFG_BLOCK_DISTANCE: block_dist = val;
        CFG_OPEN_THRESHOLD: open_thr = val;
        CFG_END_RIGHT:      end_right = val;
        CFG_END_LEFT:       end_left = val;
        CFG_ROW_MARGIN:     row_margin = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [9:0] clamp(logic [9:0] v);
      return (v > max_dist || v < min_dist) ? max_dist : v;
    endfunction

    function void add_cmd(cmd_t c, logic [HOLD_WIDTH-1:0] h);
      expected_cmd_t e;
      e = '0;
      e.word.motor_command = c;
      e.word.hold_ms = h;
      burst.push_back(e);
    endfunction

    // Updates the state for one accepted event and queues the commands it causes.
    function void note_event(kind_t kind, logic [9:0] r_raw, logic [9:0] l_raw,
                             logic [9:0] f_raw);
      logic [9:0] r, l, f;
      r = clamp(r_raw);
      l = clamp(l_raw);
      f = clamp(f_raw);
      burst.delete();
      case (kind)
        KIND_LEFT: begin
          if (left_pulses != '1) left_pulses++;
        end
        KIND_START: mode = MODE_CODE_FIND;
        KIND_SAMPLE: begin
          if (mode == MODE_CODE_FIND) begin
            add_cmd(CMD_STRAIGHT, HOLD_NONE);
            if (f <= block_dist) begin
              row_length = left_pulses;
              if (r <= block_dist) begin
                add_cmd(CMD_STOP, HOLD_PAUSE);
                add_cmd(CMD_LEFT, HOLD_LEFT);
                turn_left_next = 1'b0;
              end else if (l <= block_dist) begin
                add_cmd(CMD_STOP, HOLD_PAUSE);
                add_cmd(CMD_RIGHT, HOLD_RIGHT);
                turn_left_next = 1'b1;
              end
              mode = MODE_CODE_SCAN;
              left_pulses = '0;
            end
          end else if (mode == MODE_CODE_SCAN) begin
            add_cmd(CMD_STRAIGHT, HOLD_NONE);
            // The row end sum is taken one bit wider so that it cannot wrap.
            if ({1'b0, left_pulses} >= {1'b0, row_length} + 17'(row_margin)) begin
              if (l >= open_thr && turn_left_next) begin
                add_cmd(CMD_STOP, HOLD_PAUSE);
                add_cmd(CMD_LEFT, HOLD_LEFT);
                add_cmd(CMD_STOP, HOLD_NONE);
                turn_left_next = 1'b0;
              end else if (r >= open_thr && !turn_left_next) begin
                add_cmd(CMD_STOP, HOLD_PAUSE);
                add_cmd(CMD_RIGHT, HOLD_RIGHT);
                add_cmd(CMD_STOP, HOLD_NONE);
                turn_left_next = 1'b1;
              end else if ((r < end_right && !turn_left_next) ||
                           (l < end_left && turn_left_next)) begin
                mode = MODE_CODE_STOP;
              end
              left_pulses = '0;
            end
          end else begin
            mode = MODE_CODE_STOP;
            add_cmd(CMD_STOP, HOLD_NONE);
          end
        end
        default: ;
      endcase
      foreach (burst[i]) begin
        burst[i].word.mode_now = mode;
        burst[i].word.led_on = (mode == MODE_CODE_STOP);
        burst[i].last = (i == burst.size() - 1);
        expected.push_back(burst[i]);
      end
    endfunction

    function void check_result(logic [$bits(result_t)-1:0] data, logic last);
      result_t       got;
      expected_cmd_t want;
      got = data;
      if (expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected command: cmd %0d hold %0d mode %0d led %0d last %0d",
                   got.motor_command, got.hold_ms, got.mode_now, got.led_on, last);
      end else begin
        want = expected.pop_front();
        if (got.motor_command !== want.word.motor_command ||
            got.hold_ms !== want.word.hold_ms || got.mode_now !== want.word.mode_now ||
            got.led_on !== want.word.led_on || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"command mismatch: expected cmd %0d hold %0d mode %0d led %0d ",
                      "last %0d, got cmd %0d hold %0d mode %0d led %0d last %0d"},
                     want.word.motor_command, want.word.hold_ms, want.word.mode_now,
                     want.word.led_on, want.last, got.motor_command, got.hold_ms,
                     got.mode_now, got.led_on, last);
        end
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [31:0]                 s_tdata;
  logic [KIND_WIDTH-1:0]       s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [$bits(result_t)-1:0]  m_tdata;
  logic                        m_tlast;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]  cfg_index;
  logic [9:0]                  cfg_data;

  nav_scoreboard sb;
  bit            quick;
  bit            hold_request;
  int            events_sent;
  int            idle_cycles;

  coverage_navigation_fsm_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: long ready runs, short stalls, an occasional long stall, and
  // a very long hold-off on request so that the unit backs up into its input.
  initial begin : ready_gen
    int hold_left;
    int run_left;
    m_tready = 1'b0;
    hold_left = 0;
    run_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 250;
        run_left = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (run_left > 0) begin
        m_tready <= 1'b1;
        run_left--;
      end else begin
        case ($urandom_range(0, 7))
          0:       hold_left = $urandom_range(20, 60);
          1, 2, 3: hold_left = $urandom_range(1, 3);
          default: run_left = $urandom_range(5, 40);
        endcase
      end
    end
  end

  function automatic int pick_gap();
    case ($urandom_range(0, 15))
      0:                return $urandom_range(10, 40);
      1, 2, 3, 4, 5:    return $urandom_range(1, 3);
      default:          return 0;
    endcase
  endfunction

  // Distances cluster around the current thresholds, with some extremes.
  function automatic logic [9:0] pick_dist();
    logic [9:0] base;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return 10'($urandom_range(0, 1023));
      default: begin
        case ($urandom_range(0, 4))
          0:       base = sb.max_dist;
          1:       base = sb.block_dist;
          2:       base = sb.open_thr;
          3:       base = sb.end_right;
          default: base = sb.end_left;
        endcase
        return base + 10'($urandom_range(0, 4)) - 10'd2;
      end
    endcase
  endfunction

  task automatic send_event(kind_t kind, logic [9:0] r, logic [9:0] l, logic [9:0] f);
    int gap;
    gap = quick ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, f, l, r};
    do @(posedge clk); while (!s_tready);
    sb.note_event(kind, r, l, f);
    events_sent++;
  endtask

  task automatic pulse_left(int count);
    repeat (count) send_event(KIND_LEFT, pick_dist(), pick_dist(), pick_dist());
  endtask

  // Pulse and start events give no command, so the unit may still be busy
  // with one after the last command has come back.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [9:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [9:0] mx, logic [9:0] mn, logic [9:0] blk,
                                logic [9:0] opn, logic [9:0] er, logic [9:0] el,
                                logic [9:0] mg);
    settle();
    write_reg(CFG_MAX_DISTANCE, mx);
    write_reg(CFG_MIN_DISTANCE, mn);
    write_reg(CFG_BLOCK_DISTANCE, blk);
    write_reg(CFG_OPEN_THRESHOLD, opn);
    write_reg(CFG_END_RIGHT, er);
    write_reg(CFG_END_LEFT, el);
    write_reg(CFG_ROW_MARGIN, mg);
  endtask

  // One coverage run: start, find the first wall, then rows with pulse counts
  // near the row end, plus some stray events.
  task automatic run_course();
    int rows;
    int need;
    quick = ($urandom_range(0, 3) == 0);
    send_event(KIND_START, pick_dist(), pick_dist(), pick_dist());
    rows = $urandom_range(1, 5);
    repeat (rows) begin
      if (sb.mode == MODE_CODE_SCAN) begin
        need = int'(sb.row_length) + int'(sb.row_margin) - int'(sb.left_pulses);
        need += int'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0) need -= 2;
        if (need < 0) need = 0;
      end else begin
        need = $urandom_range(0, 4);
      end
      pulse_left(need);
      if ($urandom_range(0, 4) == 0)
        send_event(kind_t'($urandom_range(0, 3)), 10'($urandom), 10'($urandom),
                   10'($urandom));
      send_event(KIND_SAMPLE, pick_dist(), pick_dist(), pick_dist());
      if (sb.mode == MODE_CODE_STOP) break;
    end
    quick = 1'b0;
  endtask

  task automatic run_phase();
    int first;
    first = events_sent;
    while (events_sent - first < PHASE_EVENTS) run_course();
  endtask

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = KIND_SAMPLE;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_MAX_DISTANCE;
    cfg_data     = '0;
    quick        = 1'b0;
    hold_request = 1'b0;
    events_sent  = 0;
    idle_cycles  = 0;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings.
    send_event(KIND_SAMPLE, 10'd0, 10'd1023, 10'd1023);   // stop mode, clamped readings
    send_event(KIND_LEFT, '1, '1, '1);
    send_event(KIND_RIGHT, '0, '0, '0);
    send_event(KIND_START, '0, '0, '0);
    send_event(KIND_SAMPLE, 10'd25, 10'd25, 10'd30);      // find, nothing ahead
    send_event(KIND_SAMPLE, 10'd1, 10'd10, 10'd20);       // right clamps open, left blocked
    send_event(KIND_SAMPLE, 10'd30, 10'd30, 10'd30);      // scan, row not done
    pulse_left(4);
    send_event(KIND_SAMPLE, 10'd10, 10'd17, 10'd40);      // left U-turn at threshold
    pulse_left(4);
    send_event(KIND_SAMPLE, 10'd13, 10'd30, 10'd30);      // right side closed: coverage ends
    send_event(KIND_START, '0, '0, '0);
    send_event(KIND_SAMPLE, 10'd20, 10'd20, 10'd2);       // both sides blocked: turn left
    pulse_left(3);
    send_event(KIND_SAMPLE, 10'd16, 10'd16, 10'd41);      // row end with no turn and no end
    send_event(KIND_START, '0, '0, '0);                   // start again from scan
    send_event(KIND_SAMPLE, 10'd21, 10'd1023, 10'd19);    // obstacle with both sides open

    // Back-to-back samples while the output side holds off for a long time.
    quick = 1'b1;
    hold_request = 1'b1;
    repeat (12) send_event(KIND_SAMPLE, pick_dist(), pick_dist(), pick_dist());
    quick = 1'b0;

    apply_settings('0, '0, '0, '0, '0, '0, '0);
    run_phase();
    apply_settings('1, '1, '1, '1, '1, '1, 10'd6);
    run_phase();
    apply_settings(10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                   10'($urandom), 10'($urandom), 10'($urandom_range(0, 8)));
    run_phase();
    apply_settings(10'($urandom_range(30, 60)), 10'($urandom_range(0, 5)),
                   10'($urandom_range(10, 30)), 10'($urandom_range(10, 30)),
                   10'($urandom_range(5, 20)), 10'($urandom_range(5, 20)),
                   10'($urandom_range(0, 8)));
    run_phase();

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/cfn_pkg.sv
hw/rtl/cfn_cfg.sv
hw/rtl/cfn_step.sv
hw/rtl/cfn_burst.sv
hw/rtl/coverage_navigation_fsm_unit.sv
hw/rtl/cfn_checker.sv
bench/coverage_navigation_fsm_unit_test.sv
